// ----- rtl/rrps_pkg.sv -----
// shared types and constants of the round robin pair scheduler
// no dependencies; used by every rtl file of the block
package rrps_pkg;

  localparam int MAX_PLAYERS = 64;
  localparam int HALF_SLOTS  = 32;

  localparam int PLAYER_W = 6;
  localparam int ENC_W    = 8;
  localparam int GAME_W   = 16;
  localparam int ROUND_W  = 16;
  localparam int PCNT_W   = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_COUNT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENCOUNTER_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FINAL_GAME_COUNT = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SCAN
  } state_e;

  typedef struct packed {
    logic load;
    logic rotate;
    logic single;
  } cell_ctl_t;

endpackage

// ----- rtl/rrps_cell.sv -----
// one column of the circle: a top and a bottom seat, loaded or rotated
// depends on rrps_pkg
module rrps_cell #(
  parameter int PW = 6
) (
  input  logic               clk_i,
  input  rrps_pkg::cell_ctl_t ctl_i,
  input  logic               active_i,
  input  logic               last_i,
  input  logic [PW-1:0]      ld_top_i,
  input  logic [PW-1:0]      ld_bot_i,
  input  logic [PW-1:0]      left_i,
  input  logic [PW-1:0]      right_i,
  output logic [PW-1:0]      top_o,
  output logic [PW-1:0]      bot_o
);

  logic [PW-1:0] top_q, top_d;
  logic [PW-1:0] bot_q, bot_d;

  always_comb begin
    top_d = top_q;
    bot_d = bot_q;
    if (ctl_i.load) begin
      top_d = ld_top_i;
      bot_d = ld_bot_i;
    end else if (ctl_i.rotate && active_i) begin
      top_d = left_i;
      if (last_i) begin
        bot_d = ctl_i.single ? bot_q : top_q;
      end else begin
        bot_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    bot_q <= bot_d;
  end

  assign top_o = top_q;
  assign bot_o = bot_q;

endmodule

// ----- rtl/rrps_mod.sv -----
// iterative remainder of game number by encounter length, one bit a cycle
// depends on rrps_pkg
module rrps_mod (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [rrps_pkg::GAME_W-1:0]  dividend_i,
  input  logic [rrps_pkg::ENC_W-1:0]   divisor_i,
  output logic                         done_o,
  output logic [rrps_pkg::ENC_W-1:0]   rem_o
);

  localparam int CNT_W = $clog2(rrps_pkg::GAME_W);

  logic                        run_q, run_d;
  logic                        done_q, done_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic [rrps_pkg::GAME_W-1:0] num_q, num_d;
  logic [rrps_pkg::ENC_W-1:0]  div_q, div_d;
  logic [rrps_pkg::ENC_W-1:0]  rem_q, rem_d;
  logic [rrps_pkg::ENC_W:0]    trial;

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    div_d  = div_q;
    rem_d  = rem_q;
    trial  = {rem_q, num_q[rrps_pkg::GAME_W-1]};
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      num_d = dividend_i;
      div_d = divisor_i;
      rem_d = '0;
    end else if (run_q) begin
      num_d = {num_q[rrps_pkg::GAME_W-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        rem_d = rrps_pkg::ENC_W'(trial - {1'b0, div_q});
      end else begin
        rem_d = rrps_pkg::ENC_W'(trial);
      end
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(rrps_pkg::GAME_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ----- rtl/round_robin_pair_scheduler.sv -----
// round robin pair scheduler, circle method over a row of seat cells
// depends on rrps_pkg, rrps_cell, rrps_mod
// sequence: a game number past the end is answered with no division; else a
//   bit-serial remainder comes first, a nonzero one gives the held pair, if
//   any, as a repeat, and a zero one scans columns and rotates rows anew
// throughput: one request at a time, busy stays high until the result is set
// reset: rows rebuilt for two players in the first cycle, counters cleared
module round_robin_pair_scheduler #(
  parameter int MAX_PLAYERS = rrps_pkg::MAX_PLAYERS,
  parameter int HALF_SLOTS  = rrps_pkg::HALF_SLOTS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [rrps_pkg::GAME_W-1:0]      game_number_i,
  output logic                             strobe_o,
  output logic                             pair_valid_o,
  output logic [rrps_pkg::PLAYER_W-1:0]    first_player_o,
  output logic [rrps_pkg::PLAYER_W-1:0]    second_player_o,
  output logic [rrps_pkg::ROUND_W-1:0]     round_index_o,
  output logic                             repeated_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [rrps_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [rrps_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int LIM = (MAX_PLAYERS < 2 * HALF_SLOTS) ? MAX_PLAYERS : 2 * HALF_SLOTS;
  localparam int CW  = $clog2(LIM + 1);
  localparam int PW  = $clog2(2 * HALF_SLOTS);
  localparam int HW  = $clog2(HALF_SLOTS + 1);
  localparam int CIW = $clog2(HALF_SLOTS);

  rrps_pkg::state_e state_q, state_d;

  logic [rrps_pkg::PCNT_W-1:0]   pcount_q;
  logic [rrps_pkg::ENC_W-1:0]    enc_q;
  logic [rrps_pkg::GAME_W-1:0]   final_q;
  logic                          rebuild_q, rebuild_d;
  logic [HW-1:0]                 col_q, col_d;
  logic [rrps_pkg::ROUND_W-1:0]  round_q, round_d;
  logic                          held_valid_q, held_valid_d;
  logic [rrps_pkg::PLAYER_W-1:0] held_first_q, held_first_d;
  logic [rrps_pkg::PLAYER_W-1:0] held_second_q, held_second_d;

  logic                          strobe_q, strobe_d;
  logic                          pvalid_q, pvalid_d;
  logic [rrps_pkg::PLAYER_W-1:0] first_q, first_d;
  logic [rrps_pkg::PLAYER_W-1:0] second_q, second_d;
  logic [rrps_pkg::ROUND_W-1:0]  oround_q, oround_d;
  logic                          rep_q, rep_d;

  logic                          accept;
  logic                          fin_hit;
  logic                          mod_start;
  logic                          mod_done;
  logic [rrps_pkg::ENC_W-1:0]    mod_rem;
  logic [rrps_pkg::ENC_W-1:0]    enc_eff;
  logic [CW-1:0]                 eff_p;
  logic [HW-1:0]                 half;
  logic [HW:0]                   cnt;
  logic                          col_wrap;
  logic [PW-1:0]                 top_sel, bot_sel;
  logic                          pair_ok;
  logic                          rotate;
  rrps_pkg::cell_ctl_t           ctl;

  logic [PW-1:0] top_row [HALF_SLOTS];
  logic [PW-1:0] bot_row [HALF_SLOTS];

  assign accept      = start && !busy;
  assign busy        = (state_q != rrps_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign fin_hit     = (game_number_i >= final_q);
  assign enc_eff     = (enc_q == '0) ? rrps_pkg::ENC_W'(1) : enc_q;

  // effective player count and row length
  always_comb begin
    if (pcount_q < rrps_pkg::PCNT_W'(2)) begin
      eff_p = CW'(2);
    end else if (32'(pcount_q) > 32'(LIM)) begin
      eff_p = CW'(LIM);
    end else begin
      eff_p = CW'(pcount_q);
    end
  end

  assign half = HW'((32'(eff_p) + 32'd1) >> 1);
  assign cnt  = {half, 1'b0};

  assign ctl.load   = rebuild_q;
  assign ctl.rotate = rotate;
  assign ctl.single = (half == HW'(1));

  for (genvar i = 0; i < HALF_SLOTS; i++) begin : g_cell
    logic [PW-1:0] ld_top, ld_bot, left, right;
    logic          active, last;

    assign active = (HW'(i) < half);
    assign last   = (HW'(i + 1) == half);
    assign ld_top = active ? PW'(i) : '0;
    assign ld_bot = active ? PW'(cnt - (HW + 1)'(1) - (HW + 1)'(i)) : '0;

    if (i == 0) begin : g_left0
      assign left = top_row[0];
    end else if (i == 1) begin : g_left1
      assign left = bot_row[0];
    end else begin : g_leftn
      assign left = top_row[i-1];
    end

    if (i == HALF_SLOTS - 1) begin : g_right_end
      assign right = bot_row[i];
    end else begin : g_right
      assign right = bot_row[i+1];
    end

    rrps_cell #(
      .PW (PW)
    ) u_cell (
      .clk_i    (clk_i),
      .ctl_i    (ctl),
      .active_i (active),
      .last_i   (last),
      .ld_top_i (ld_top),
      .ld_bot_i (ld_bot),
      .left_i   (left),
      .right_i  (right),
      .top_o    (top_row[i]),
      .bot_o    (bot_row[i])
    );
  end

  rrps_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (game_number_i),
    .divisor_i  (enc_eff),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  assign col_wrap = (col_q >= half);
  assign top_sel  = top_row[col_q[CIW-1:0]];
  assign bot_sel  = bot_row[col_q[CIW-1:0]];
  assign pair_ok  = (32'(top_sel) < 32'(eff_p)) && (32'(bot_sel) < 32'(eff_p));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rrps_pkg::ST_IDLE: begin
        if (start && !fin_hit) begin
          state_d = rrps_pkg::ST_DIV;
        end
      end
      rrps_pkg::ST_DIV: begin
        if (mod_done) begin
          state_d = (mod_rem != '0) ? rrps_pkg::ST_IDLE : rrps_pkg::ST_SCAN;
        end
      end
      rrps_pkg::ST_SCAN: begin
        if (!col_wrap && pair_ok) begin
          state_d = rrps_pkg::ST_IDLE;
        end
      end
      default: state_d = rrps_pkg::ST_IDLE;
    endcase
  end

  // datapath and result
  always_comb begin
    mod_start     = 1'b0;
    rotate        = 1'b0;
    rebuild_d     = 1'b0;
    col_d         = col_q;
    round_d       = round_q;
    held_valid_d  = held_valid_q;
    held_first_d  = held_first_q;
    held_second_d = held_second_q;
    strobe_d      = 1'b0;
    pvalid_d      = 1'b0;
    first_d       = '0;
    second_d      = '0;
    oround_d      = round_q;
    rep_d         = 1'b0;

    unique case (state_q)
      rrps_pkg::ST_IDLE: begin
        if (accept) begin
          if (fin_hit) begin
            strobe_d = 1'b1;
          end else begin
            mod_start = 1'b1;
          end
        end
      end
      rrps_pkg::ST_DIV: begin
        if (mod_done && (mod_rem != '0)) begin
          strobe_d = 1'b1;
          rep_d    = 1'b1;
          if (held_valid_q) begin
            pvalid_d = 1'b1;
            first_d  = held_first_q;
            second_d = held_second_q;
          end
        end
      end
      rrps_pkg::ST_SCAN: begin
        if (col_wrap) begin
          rotate  = 1'b1;
          col_d   = '0;
          round_d = round_q + rrps_pkg::ROUND_W'(1);
        end else begin
          col_d = col_q + HW'(1);
          if (pair_ok) begin
            strobe_d      = 1'b1;
            pvalid_d      = 1'b1;
            first_d       = rrps_pkg::PLAYER_W'(top_sel);
            second_d      = rrps_pkg::PLAYER_W'(bot_sel);
            held_valid_d  = 1'b1;
            held_first_d  = rrps_pkg::PLAYER_W'(top_sel);
            held_second_d = rrps_pkg::PLAYER_W'(bot_sel);
          end
        end
      end
      default: ;
    endcase

    // player count write sets rebuild_q, which then rebuilds the rows
    if (cfg_valid_i && (cfg_index_i == rrps_pkg::CFG_PLAYER_COUNT)) begin
      rebuild_d = 1'b1;
    end
    if (rebuild_q) begin
      col_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= rrps_pkg::ST_IDLE;
      pcount_q     <= rrps_pkg::PCNT_W'(2);
      enc_q        <= rrps_pkg::ENC_W'(1);
      final_q      <= rrps_pkg::GAME_W'(1);
      rebuild_q    <= 1'b1;
      col_q        <= '0;
      round_q      <= '0;
      held_valid_q <= 1'b0;
      strobe_q     <= 1'b0;
    end else begin
      state_q      <= state_d;
      rebuild_q    <= rebuild_d;
      col_q        <= col_d;
      round_q      <= round_d;
      held_valid_q <= held_valid_d;
      strobe_q     <= strobe_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          rrps_pkg::CFG_PLAYER_COUNT:     pcount_q <= cfg_data_i[rrps_pkg::PCNT_W-1:0];
          rrps_pkg::CFG_ENCOUNTER_LENGTH: enc_q    <= cfg_data_i[rrps_pkg::ENC_W-1:0];
          rrps_pkg::CFG_FINAL_GAME_COUNT: final_q  <= cfg_data_i[rrps_pkg::GAME_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_first_q  <= '0;
      held_second_q <= '0;
    end else begin
      held_first_q  <= held_first_d;
      held_second_q <= held_second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pvalid_q <= pvalid_d;
    first_q  <= first_d;
    second_q <= second_d;
    oround_q <= oround_d;
    rep_q    <= rep_d;
  end

  assign strobe_o        = strobe_q;
  assign pair_valid_o    = pvalid_q;
  assign first_player_o  = first_q;
  assign second_player_o = second_q;
  assign round_index_o   = oround_q;
  assign repeated_o      = rep_q;

endmodule
